/* rtl/als_pkg.sv */
// Shared types, codes and helpers for the access-state log lookup block.
// No dependencies; compile first.
package als_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned OFS_W   = 36;
  localparam int unsigned GRP_W   = 16;
  localparam int unsigned STATE_W = 8;
  localparam int unsigned PRIO_W  = 7;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned REG_W   = 2;

  // Register indexes on the write port.
  localparam logic [REG_W-1:0] REG_TARGET_NS  = 2'd0;
  localparam logic [REG_W-1:0] REG_TARGET_GRP = 2'd1;
  localparam logic [REG_W-1:0] REG_LOG_LEN    = 2'd2;

  localparam logic [WORD_W-1:0] RST_TARGET_NS  = 32'd1;
  localparam logic [WORD_W-1:0] RST_TARGET_GRP = 32'd0;
  localparam logic [LEN_W-1:0]  RST_LOG_LEN    = 24'd4096;

  // Page layout: 16-byte header, 32-byte group descriptors.
  localparam logic [OFS_W-1:0]   HDR_BYTES  = 36'd16;
  localparam logic [OFS_W-1:0]   DESC_BYTES = 36'd32;
  localparam logic [IDX_W-1:0]   HDR_CNT_WORD   = 3'd2;
  localparam logic [IDX_W-1:0]   HDR_LAST_WORD  = 3'd3;
  localparam logic [IDX_W-1:0]   DESC_GID_WORD  = 3'd0;
  localparam logic [IDX_W-1:0]   DESC_NCNT_WORD = 3'd1;
  localparam logic [IDX_W-1:0]   DESC_ST_WORD   = 3'd4;
  localparam logic [IDX_W-1:0]   DESC_LAST_WORD = 3'd7;

  localparam logic signed [PRIO_W-1:0] PRIO_NONE = -7'sd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DESC   = 2'd1,
    PH_IDS    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] target_namespace;
    logic [WORD_W-1:0] target_group;
    logic [LEN_W-1:0]  log_length_bytes;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    status_t            status;
    logic [STATE_W-1:0] access_state;
  } res_t;

  // Access state to path priority.
  function automatic logic signed [PRIO_W-1:0] priority_of(input logic [STATE_W-1:0] st);
    logic signed [PRIO_W-1:0] p;
    case (st)
      8'd1:        p = 7'sd50;
      8'd2:        p = 7'sd10;
      8'd3, 8'd15: p = 7'sd1;
      8'd4:        p = 7'sd0;
      default:     p = PRIO_NONE;
    endcase
    return p;
  endfunction

endpackage

/* rtl/als_if.sv */
// Valid/ready channel interfaces for log words in and lookup results out.
// Depends on als_pkg.
interface als_in_if import als_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] log_word;
  logic              page_end;

  modport source (output valid, log_word, page_end, input ready);
  modport sink   (input valid, log_word, page_end, output ready);
endinterface

interface als_out_if import als_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [STATE_W-1:0]       access_state;
  logic signed [PRIO_W-1:0] priority_res;

  modport source (output valid, status, access_state, priority_res, input ready);
  modport sink   (input valid, status, access_state, priority_res, output ready);
endinterface

/* rtl/als_parser.sv */
// Log page parser: walks header, descriptors and id lists one word per step.
// Depends on als_pkg.
module als_parser import als_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [WORD_W-1:0] word,
  input  logic              last,
  input  cfg_t              cfg,
  output res_t              res
);

  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   word_index, word_index_next;
  logic [OFS_W-1:0]   byte_offset, byte_offset_next;
  logic [GRP_W-1:0]   groups_left, groups_left_next;
  logic [WORD_W-1:0]  ids_left, ids_left_next;
  logic [WORD_W-1:0]  group_id_seen, group_id_seen_next;
  logic [STATE_W-1:0] state_seen, state_seen_next;

  logic [OFS_W-1:0]  len_ext;
  logic [OFS_W-1:0]  desc_end;
  logic              next_desc_fits;
  logic [GRP_W-1:0]  groups_dec;
  logic [WORD_W-1:0] ids_dec;
  logic              group_hit;
  logic              desc_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      word_index    <= '0;
      byte_offset   <= '0;
      groups_left   <= '0;
      ids_left      <= '0;
      group_id_seen <= '0;
      state_seen    <= '0;
    end else begin
      phase         <= phase_next;
      word_index    <= word_index_next;
      byte_offset   <= byte_offset_next;
      groups_left   <= groups_left_next;
      ids_left      <= ids_left_next;
      group_id_seen <= group_id_seen_next;
      state_seen    <= state_seen_next;
    end
  end

  assign len_ext        = {{(OFS_W-LEN_W){1'b0}}, cfg.log_length_bytes};
  // end of this descriptor plus its id list
  assign desc_end       = byte_offset + DESC_BYTES + {2'b00, word, 2'b00};
  assign next_desc_fits = (byte_offset + DESC_BYTES) <= len_ext;
  assign groups_dec     = groups_left - 1'b1;
  assign ids_dec        = ids_left - 1'b1;
  assign group_hit      = (cfg.target_group != '0) && (cfg.target_group == group_id_seen);

  always_comb begin
    phase_next         = phase;
    word_index_next    = word_index;
    byte_offset_next   = byte_offset;
    groups_left_next   = groups_left;
    ids_left_next      = ids_left;
    group_id_seen_next = group_id_seen;
    state_seen_next    = state_seen;
    res.emit           = 1'b0;
    res.status         = ST_NOTFOUND;
    res.access_state   = '0;
    desc_over          = 1'b0;

    if (step) begin
      case (phase)
        PH_HEADER: begin
          if (word_index == HDR_CNT_WORD) begin
            groups_left_next = word[GRP_W-1:0];
          end
          if (word_index == HDR_LAST_WORD) begin
            byte_offset_next = HDR_BYTES;
            if (groups_left_next == '0) begin
              res.emit = 1'b1; res.status = ST_NOTFOUND; phase_next = PH_DONE;
            end else if ((HDR_BYTES + DESC_BYTES) > len_ext) begin
              res.emit = 1'b1; res.status = ST_OVERFLOW; phase_next = PH_DONE;
            end else begin
              phase_next      = PH_DESC;
              word_index_next = '0;
            end
          end else begin
            word_index_next = word_index + 1'b1;
          end
        end
        PH_DESC: begin
          if (word_index == DESC_GID_WORD) begin
            group_id_seen_next = word;
          end
          if (word_index == DESC_NCNT_WORD) begin
            ids_left_next    = word;
            byte_offset_next = desc_end;
            if (desc_end > len_ext) begin
              res.emit   = 1'b1;
              res.status = ST_OVERFLOW;
              phase_next = PH_DONE;
              desc_over  = 1'b1;
            end
          end
          if (word_index == DESC_ST_WORD) begin
            state_seen_next = word[STATE_W-1:0];
          end
          if (!desc_over) begin
            if (word_index == DESC_LAST_WORD) begin
              if (ids_left != '0) begin
                phase_next = PH_IDS;
              end else if (group_hit) begin
                res.emit = 1'b1; res.status = ST_FOUND;
                res.access_state = state_seen; phase_next = PH_DONE;
              end else begin
                groups_left_next = groups_dec;
                if (groups_dec == '0) begin
                  res.emit = 1'b1; res.status = ST_NOTFOUND; phase_next = PH_DONE;
                end else if (!next_desc_fits) begin
                  res.emit = 1'b1; res.status = ST_OVERFLOW; phase_next = PH_DONE;
                end else begin
                  phase_next      = PH_DESC;
                  word_index_next = '0;
                end
              end
            end else begin
              word_index_next = word_index + 1'b1;
            end
          end
        end
        PH_IDS: begin
          if (word == cfg.target_namespace) begin
            res.emit = 1'b1; res.status = ST_FOUND;
            res.access_state = state_seen; phase_next = PH_DONE;
          end else begin
            ids_left_next = ids_dec;
            if (ids_dec == '0) begin
              if (group_hit) begin
                res.emit = 1'b1; res.status = ST_FOUND;
                res.access_state = state_seen; phase_next = PH_DONE;
              end else begin
                groups_left_next = groups_dec;
                if (groups_dec == '0) begin
                  res.emit = 1'b1; res.status = ST_NOTFOUND; phase_next = PH_DONE;
                end else if (!next_desc_fits) begin
                  res.emit = 1'b1; res.status = ST_OVERFLOW; phase_next = PH_DONE;
                end else begin
                  phase_next      = PH_DESC;
                  word_index_next = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase

      // page end: truncated page reads as overflow, then rearm for the next page
      if (last) begin
        if (phase_next != PH_DONE) begin
          res.emit         = 1'b1;
          res.status       = ST_OVERFLOW;
          res.access_state = '0;
        end
        phase_next         = PH_HEADER;
        word_index_next    = '0;
        byte_offset_next   = '0;
        groups_left_next   = '0;
        ids_left_next      = '0;
        group_id_seen_next = '0;
        state_seen_next    = '0;
      end
    end
  end

endmodule

/* rtl/ana_log_state_lookup_top.sv */
// Top level of the access-state log lookup block: config registers, input
// word register, parser and result register. Depends on als_pkg, als_if, als_parser.
//
// Usage:
//  - log_in carries the log page as 32-bit words; page_end marks
//    the final word of a page. A word is taken when valid and ready are high.
//  - res_out gives at most one result per page: status (found, overflow, not
//    found), the matching access state byte and its priority (-1 if none).
//  - wr_en/wr_index/wr_data write the target namespace, target group and log
//    length; write only while no page is in flight.
//  - A taken word is held in the input word register and parsed once the result
//    register is free or draining; a result it settles goes to the result register.
//  - Throughput: one word per cycle unless the result register stalls. The parser
//    state updates once per word (36-bit offset adds, compares to the log length).
//  - A result that waits in the output register does not block the input while
//    the receiver takes it; if the receiver stalls, one word more sits in the
//    input register and then log_in.ready drops until the result is taken.
//  - Reset: parser back to the header phase, both registers empty, config
//    registers to target namespace 1, no group match, log length 4096.
module ana_log_state_lookup_top import als_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [REG_W-1:0]  wr_index,
  input  logic [WORD_W-1:0] wr_data,
  als_in_if.sink            log_in,
  als_out_if.source         res_out
);

  cfg_t cfg;

  // input word register
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_last;
  logic              in_ready;
  logic              step;

  // result register
  logic                     out_valid;
  status_t                  out_status;
  logic [STATE_W-1:0]       out_state;
  logic signed [PRIO_W-1:0] out_prio;

  res_t res;

  // config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_namespace <= RST_TARGET_NS;
      cfg.target_group     <= RST_TARGET_GRP;
      cfg.log_length_bytes <= RST_LOG_LEN;
    end else if (wr_en) begin
      case (wr_index)
        REG_TARGET_NS:  cfg.target_namespace <= wr_data;
        REG_TARGET_GRP: cfg.target_group     <= wr_data;
        REG_LOG_LEN:    cfg.log_length_bytes <= wr_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // parse the held word when the result register is free or draining
  assign step     = in_valid && (!out_valid || res_out.ready);
  assign in_ready = !in_valid || step;
  assign log_in.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= log_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && log_in.valid) begin
      in_word <= log_in.log_word;
      in_last <= log_in.page_end;
    end
  end

  als_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .word (in_word),
    .last (in_last),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.emit;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // priority only for a found state; overflow and not found map to -1
  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_status <= res.status;
      out_state  <= res.access_state;
      out_prio   <= (res.status == ST_FOUND) ? priority_of(res.access_state) : PRIO_NONE;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.status       = out_status;
  assign res_out.access_state = out_state;
  assign res_out.priority_res = out_prio;

endmodule
